// ===== src/jdrf_pkg.sv =====
// jdrf_pkg: shared types, constants and register codes of the joint deflection rate filter
// depends on nothing; imported by every module of the block
package jdrf_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 31;
	localparam int DVD_W         = 80;
	localparam int DEN_W         = 64;
	localparam int STEP_W        = 7;
	localparam int FRAC_W        = 16;
	localparam int WIN_W         = 7;
	localparam int WINDOW_DEPTH_DEF = 64;

	localparam logic [CFG_W-1:0] STIFF_RST = CFG_W'(65536);
	localparam logic [CFG_W-1:0] DAMP_RST  = '0;
	localparam logic [CFG_W-1:0] DT_RST    = CFG_W'(65);
	localparam logic [WIN_W-1:0] WIN_RST   = WIN_W'(1);

	typedef enum logic [2:0] {
		REG_STIFF_PITCH = 3'd0,
		REG_STIFF_ROLL  = 3'd1,
		REG_DAMP_PITCH  = 3'd2,
		REG_DAMP_ROLL   = 3'd3,
		REG_STEP_PERIOD = 3'd4,
		REG_FILTER_EN   = 3'd5,
		REG_WINDOW_LEN  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] torque_pitch;
		logic signed [DATA_W-1:0] torque_roll;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] deflection_pitch;
		logic signed [DATA_W-1:0] deflection_roll;
		logic signed [DATA_W-1:0] rate_pitch;
		logic signed [DATA_W-1:0] rate_roll;
	} out_item_t;

	// per-axis settings seen by one lane
	typedef struct packed {
		logic [CFG_W-1:0] stiff;
		logic [CFG_W-1:0] damp;
		logic [CFG_W-1:0] dt;
		logic             filter_en;
	} lane_cfg_t;

	// command from the sequencer to a lane
	typedef struct packed {
		logic start;
		logic use_old;
	} lane_cmd_t;

endpackage

// ===== src/jdrf_div.sv =====
// jdrf_div: radix-2 restoring divider, one quotient bit per cycle, saturating signed result
// depends on jdrf_pkg
module jdrf_div
	import jdrf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DVD_W-1:0]         dividend,
	input  logic [DEN_W-1:0]         divisor,
	input  logic [STEP_W-1:0]        steps,
	input  logic                     neg,
	output logic                     done,
	output logic signed [DATA_W-1:0] result
);

	logic [DVD_W-1:0]  sh_q;
	logic [DEN_W-1:0]  r_q;
	logic [DEN_W-1:0]  den_q;
	logic [DATA_W-1:0] quo_q;
	logic              big_q;
	logic              neg_q;
	logic              zero_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DEN_W:0]    rr;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign rr   = {r_q, sh_q[DVD_W-1]};
	assign diff = rr - {1'b0, den_q};
	assign ge   = rr >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= dividend;
			r_q    <= '0;
			den_q  <= divisor;
			quo_q  <= '0;
			big_q  <= 1'b0;
			neg_q  <= neg;
			zero_q <= (divisor == '0);
		end else if (cnt_q != '0) begin
			sh_q  <= {sh_q[DVD_W-2:0], 1'b0};
			r_q   <= ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
			big_q <= big_q | quo_q[DATA_W-1];
		end
	end

	// saturate to the signed range, zero divisor gives the largest magnitude
	always_comb begin
		if (zero_q) begin
			result = neg_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else if (neg_q) begin
			if (big_q || (quo_q[DATA_W-1] && (quo_q[DATA_W-2:0] != '0)))
				result = {1'b1, {(DATA_W-1){1'b0}}};
			else
				result = -$signed(quo_q);
		end else begin
			if (big_q || quo_q[DATA_W-1])
				result = {1'b0, {(DATA_W-1){1'b1}}};
			else
				result = $signed(quo_q);
		end
	end

	assign done = done_q;

endmodule

// ===== src/jdrf_lane.sv =====
// jdrf_lane: one axis: deflection, rate and moving average, with its own rate history
// depends on jdrf_pkg and jdrf_div
module jdrf_lane
	import jdrf_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lane_cfg_t                cfg,
	input  lane_cmd_t                cmd,
	input  logic signed [DATA_W-1:0] torque,
	input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] wr_addr,
	input  logic [((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1)-1:0] old_addr,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
	output logic                     done,
	output logic signed [DATA_W-1:0] deflection,
	output logic signed [DATA_W-1:0] rate
);

	localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH+1);
	localparam int SW = DATA_W + CW;
	localparam int PROD_W = 2 * DATA_W;
	localparam int DIFF_W = DATA_W + 1;

	typedef enum logic [8:0] {
		L_IDLE = 9'b000000001,
		L_MUL  = 9'b000000010,
		L_PREP = 9'b000000100,
		L_DIV1 = 9'b000001000,
		L_RATE = 9'b000010000,
		L_DIV2 = 9'b000100000,
		L_SUM  = 9'b001000000,
		L_AVG  = 9'b010000000,
		L_DONE = 9'b100000000
	} lane_state_t;

	lane_state_t state_q;

	logic signed [DATA_W-1:0] hist_mem [WINDOW_DEPTH];
	logic signed [DATA_W-1:0] old_q;
	logic signed [DATA_W-1:0] torque_q;
	logic signed [DATA_W-1:0] d0_q;
	logic signed [DATA_W-1:0] delta_q;
	logic signed [DATA_W-1:0] rate_q;
	logic signed [SW-1:0]     sum_q;
	logic [PW-1:0]            wr_addr_q;
	logic [PW-1:0]            old_addr_q;
	logic [CW-1:0]            count_q;
	logic                     use_old_q;

	logic signed [PROD_W-1:0] pa_s1;
	logic signed [PROD_W-1:0] pb_s1;
	logic [PROD_W-1:0]        pd_s1;

	logic signed [PROD_W-1:0] num;
	logic [PROD_W-1:0]        num_mag;
	logic [DEN_W-1:0]         den;
	logic signed [DIFF_W-1:0] dd;
	logic [DIFF_W-1:0]        dd_mag;
	logic signed [SW-1:0]     sum_next;
	logic [SW-1:0]            sum_mag;

	logic                     div_start;
	logic [DVD_W-1:0]         div_dvd;
	logic [DEN_W-1:0]         div_den;
	logic [STEP_W-1:0]        div_steps;
	logic                     div_neg;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_res;

	assign num     = pa_s1 - pb_s1;
	assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign den     = pd_s1 + DEN_W'({cfg.damp, {FRAC_W{1'b0}}});
	assign dd      = DIFF_W'(delta_q) - DIFF_W'(d0_q);
	assign dd_mag  = dd[DIFF_W-1] ? DIFF_W'(-dd) : DIFF_W'(dd);
	assign sum_next = sum_q - (use_old_q ? SW'(old_q) : SW'(0)) + SW'(rate_q);
	assign sum_mag  = sum_next[SW-1] ? SW'(-sum_next) : SW'(sum_next);

	// divider operands by phase
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_den   = '0;
		div_steps = '0;
		div_neg   = 1'b0;
		case (state_q)
			L_PREP: begin
				div_start = 1'b1;
				div_dvd   = {num_mag, {FRAC_W{1'b0}}};
				div_den   = den;
				div_steps = STEP_W'(DVD_W);
				div_neg   = num[PROD_W-1];
			end
			L_RATE: begin
				div_start = 1'b1;
				div_dvd   = {dd_mag, {(DVD_W-DIFF_W){1'b0}}};
				div_den   = DEN_W'(cfg.dt);
				div_steps = STEP_W'(DIFF_W + FRAC_W);
				div_neg   = dd[DIFF_W-1];
			end
			L_SUM: begin
				div_start = 1'b1;
				div_dvd   = {sum_mag, {(DVD_W-SW){1'b0}}};
				div_den   = DEN_W'(count_q);
				div_steps = STEP_W'(SW);
				div_neg   = sum_next[SW-1];
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	jdrf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_den),
		.steps    (div_steps),
		.neg      (div_neg),
		.done     (div_done),
		.result   (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			d0_q    <= '0;
			sum_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: if (cmd.start) state_q <= L_MUL;
				L_MUL:  state_q <= L_PREP;
				L_PREP: state_q <= L_DIV1;
				L_DIV1: if (div_done) state_q <= L_RATE;
				L_RATE: state_q <= L_DIV2;
				L_DIV2: if (div_done) state_q <= cfg.filter_en ? L_SUM : L_DONE;
				L_SUM: begin
					sum_q   <= sum_next;
					state_q <= L_AVG;
				end
				L_AVG:  if (div_done) state_q <= L_DONE;
				L_DONE: begin
					d0_q    <= delta_q;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && cmd.start) begin
			torque_q   <= torque;
			wr_addr_q  <= wr_addr;
			old_addr_q <= old_addr;
			count_q    <= count;
			use_old_q  <= cmd.use_old;
		end
		if (state_q == L_MUL) begin
			pa_s1 <= PROD_W'(d0_q) * PROD_W'($signed({1'b0, cfg.damp}));
			pb_s1 <= PROD_W'(torque_q) * PROD_W'($signed({1'b0, cfg.dt}));
			pd_s1 <= PROD_W'(cfg.stiff) * PROD_W'(cfg.dt);
			old_q <= hist_mem[old_addr_q];
		end
		if (state_q == L_DIV1 && div_done) delta_q <= div_res;
		if ((state_q == L_DIV2 || state_q == L_AVG) && div_done) rate_q <= div_res;
		if (state_q == L_SUM) hist_mem[wr_addr_q] <= rate_q;
	end

	assign done       = (state_q == L_DONE);
	assign deflection = delta_q;
	assign rate       = rate_q;

endmodule

// ===== src/joint_deflection_rate_filter.sv =====
// joint_deflection_rate_filter: top level, configuration registers, history sequencer,
// merge of the pitch and roll lanes into the output register
// depends on jdrf_pkg and jdrf_lane
//
// usage
//   input channel in_valid/in_ready/in_data carries one torque pair per control step;
//   output channel out_valid/out_ready/out_data carries deflections and rates
//   one result per input transfer, in order
//   configuration: cfg_we with cfg_index and cfg_data writes one register per cycle;
//   the user must write only while the block is idle; the block does not enforce this
// operation
//   two lanes (pitch, roll) run side by side, each with one bit-serial divider
//   each item runs the deflection divide, then the rate divide, and with the filter
//   on, then the moving average divide; a new transfer is not taken before both lanes
//   are done and their result is in the output register
//   the next transfer may then be taken even if that result still waits there
// reset
//   arst_n clears registers to their reset values, previous deflection and sums to zero,
//   history count and pointer to zero; rate history is not cleared
// stall
//   a result waits in the output register; a second finished result waits in the lanes
module joint_deflection_rate_filter
	import jdrf_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH+1);
	localparam int LW = (CW > WIN_W) ? CW : WIN_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} top_state_t;

	top_state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] stiff_pitch_q;
	logic [CFG_W-1:0] stiff_roll_q;
	logic [CFG_W-1:0] damp_pitch_q;
	logic [CFG_W-1:0] damp_roll_q;
	logic [CFG_W-1:0] dt_q;
	logic             filt_en_q;
	logic [WIN_W-1:0] win_len_q;

	// history bookkeeping shared by both lanes
	logic [PW-1:0] ptr_q;
	logic [CW-1:0] count_q;

	logic          accept;
	logic [LW-1:0] wl_ext;
	logic [CW-1:0] len;
	logic          grow;
	logic [CW-1:0] count_new;
	logic [CW:0]   ptr_ext;
	logic [CW:0]   old_ext;
	logic [PW-1:0] old_addr;
	logic [PW-1:0] ptr_next;

	lane_cfg_t cfg_pitch;
	lane_cfg_t cfg_roll;
	lane_cmd_t cmd;

	logic                     done_pitch;
	logic                     done_roll;
	logic signed [DATA_W-1:0] defl_pitch;
	logic signed [DATA_W-1:0] defl_roll;
	logic signed [DATA_W-1:0] rate_pitch;
	logic signed [DATA_W-1:0] rate_roll;
	logic                     lanes_done;
	logic                     out_free;
	logic                     load_out;

	logic      out_valid_q;
	out_item_t out_data_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// window length zero counts as one, beyond the depth as the depth
	always_comb begin
		wl_ext = LW'(win_len_q);
		if (wl_ext == '0)
			len = CW'(1);
		else if (wl_ext > LW'(WINDOW_DEPTH))
			len = CW'(WINDOW_DEPTH);
		else
			len = CW'(wl_ext);
	end

	assign grow      = (count_q < len);
	assign count_new = grow ? count_q + CW'(1) : count_q;

	// oldest held sample sits count places behind the write pointer
	assign ptr_ext  = (CW+1)'(ptr_q);
	assign old_ext  = (ptr_ext >= (CW+1)'(count_q)) ?
	                  ptr_ext - (CW+1)'(count_q) :
	                  ptr_ext + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(count_q);
	assign old_addr = old_ext[PW-1:0];
	assign ptr_next = (ptr_q == PW'(WINDOW_DEPTH-1)) ? '0 : ptr_q + PW'(1);

	assign cfg_pitch = '{stiff: stiff_pitch_q, damp: damp_pitch_q, dt: dt_q,
	                     filter_en: filt_en_q};
	assign cfg_roll  = '{stiff: stiff_roll_q, damp: damp_roll_q, dt: dt_q,
	                     filter_en: filt_en_q};
	assign cmd       = '{start: accept, use_old: !grow};

	jdrf_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_pitch),
		.cmd        (cmd),
		.torque     (in_data.torque_pitch),
		.wr_addr    (ptr_q),
		.old_addr   (old_addr),
		.count      (count_new),
		.done       (done_pitch),
		.deflection (defl_pitch),
		.rate       (rate_pitch)
	);

	jdrf_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_roll (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_roll),
		.cmd        (cmd),
		.torque     (in_data.torque_roll),
		.wr_addr    (ptr_q),
		.old_addr   (old_addr),
		.count      (count_new),
		.done       (done_roll),
		.deflection (defl_roll),
		.rate       (rate_roll)
	);

	// both lanes run in lockstep
	assign lanes_done = done_pitch && done_roll;
	assign out_free   = !out_valid_q || out_ready;
	assign load_out   = ((state_q == S_RUN) && lanes_done && out_free) ||
	                    ((state_q == S_HOLD) && out_free);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_pitch_q <= STIFF_RST;
			stiff_roll_q  <= STIFF_RST;
			damp_pitch_q  <= DAMP_RST;
			damp_roll_q   <= DAMP_RST;
			dt_q          <= DT_RST;
			filt_en_q     <= 1'b0;
			win_len_q     <= WIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFF_PITCH: stiff_pitch_q <= cfg_data;
				REG_STIFF_ROLL:  stiff_roll_q  <= cfg_data;
				REG_DAMP_PITCH:  damp_pitch_q  <= cfg_data;
				REG_DAMP_ROLL:   damp_roll_q   <= cfg_data;
				REG_STEP_PERIOD: dt_q          <= cfg_data;
				REG_FILTER_EN:   filt_en_q     <= cfg_data[0];
				REG_WINDOW_LEN:  win_len_q     <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and history pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						if (filt_en_q) begin
							ptr_q   <= ptr_next;
							count_q <= count_new;
						end
					end
				end
				S_RUN: begin
					if (lanes_done) state_q <= out_free ? S_IDLE : S_HOLD;
				end
				S_HOLD: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, merges the two lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= '{deflection_pitch: defl_pitch, deflection_roll: defl_roll,
			                rate_pitch: rate_pitch, rate_roll: rate_roll};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
